### hdl/acl_pkg.sv
// Shared types and constants for the autocorrelation load predictor.
package acl_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;  // unsigned Q8.8 load sample
  localparam int CORR_W   = 16;  // signed Q1.15 correlation
  localparam int PRED_W   = 17;  // signed Q8.8 prediction
  localparam int LAG_W    = 6;   // lag register
  localparam int QUOT_W   = 16;  // quotient bits produced by the divider
  localparam int OP_W     = SAMPLE_W + 1;  // signed deviation operand
  localparam int PROD_W   = 2 * OP_W;      // signed product

  // Stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 56;

  // Defaults
  localparam int                WINDOW_LEN_DEF = 64;
  localparam logic [LAG_W-1:0]  LAG_RST        = 6'd1;
  localparam logic [CORR_W-1:0] CORR_MAX       = 16'h7FFF;

  // Accumulator control from the sequencer
  typedef struct packed {
    logic clear;
    logic acc_en;
  } mac_ctl_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/acl_ring.sv
// Sample ring: one write port, two registered read ports, fill-count based zero reads.
module acl_ring
  import acl_pkg::*;
#(
  parameter int DEPTH = WINDOW_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [SAMPLE_W-1:0]        wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_b_i,
  output logic [SAMPLE_W-1:0]        rd_data_a_o,
  output logic [SAMPLE_W-1:0]        rd_data_b_o,
  output logic [$clog2(DEPTH)-1:0]   oldest_o
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [IDX_W-1:0]    wr_idx_q;
  logic [CNT_W-1:0]    fill_q;
  logic [SAMPLE_W-1:0] rd_a_q, rd_b_q;

  // Write pointer and fill count; entries at or above the fill read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      fill_q   <= '0;
    end else if (wr_en_i) begin
      if (wr_idx_q == IDX_W'(DEPTH - 1)) begin
        wr_idx_q <= '0;
      end else begin
        wr_idx_q <= wr_idx_q + 1'b1;
      end
      if (fill_q != CNT_W'(DEPTH)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // Storage write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_q] <= wr_data_i;
    end
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    rd_a_q <= (CNT_W'(rd_addr_a_i) < fill_q) ? mem_q[rd_addr_a_i] : '0;
    rd_b_q <= (CNT_W'(rd_addr_b_i) < fill_q) ? mem_q[rd_addr_b_i] : '0;
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;
  assign oldest_o    = wr_idx_q;

endmodule

### hdl/acl_mac.sv
// Shared signed multiplier with a registered product and a clearable accumulator.
module acl_mac
  import acl_pkg::*;
#(
  parameter int ACC_W = PROD_W + 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctl_t                 ctl_i,
  input  logic signed [OP_W-1:0]   op_a_i,
  input  logic signed [OP_W-1:0]   op_b_i,
  output logic signed [PROD_W-1:0] prod_o,
  output logic signed [ACC_W-1:0]  acc_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Product stage
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  // Accumulate the previous cycle's product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_q <= acc_q + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

### hdl/acl_div.sv
// Restoring divider, one quotient bit per cycle, 16 quotient bits per operation.
module acl_div
  import acl_pkg::*;
#(
  parameter int W = PROD_W + 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [W-1:0]      hi_i,       // upper dividend part, must be below the divisor
  input  logic [QUOT_W-1:0] lo_i,       // lower dividend bits, shifted in MSB first
  input  logic [W-1:0]      divisor_i,
  output div_stat_t         stat_o,
  output logic [QUOT_W-1:0] quot_o
);

  localparam int STEP_W = $clog2(QUOT_W);

  logic [W-1:0]      rem_q, div_q;
  logic [QUOT_W-1:0] lo_q, quot_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [W:0]        trial;
  logic              fits;

  // One trial subtraction per cycle
  assign trial = {rem_q, lo_q[QUOT_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= hi_i;
      lo_q   <= lo_i;
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? W'(trial - {1'b0, div_q}) : trial[W-1:0];
      lo_q   <= {lo_q[QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[QUOT_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

### hdl/autocorrelation_load_predictor.sv
// Top level: sequencer around the sample ring, shared multiplier and serial divider.
//
// Each accepted load sample is written into a ring of WINDOW_LEN samples (zero after
// reset), and one result comes back: the window's normalized autocorrelation at lag 1
// and at the lag in the corr_lag register (Q1.15, zero for a flat window or a lag of
// WINDOW_LEN or more), plus the next-load prediction, newest sample times the lag-1
// correlation, in signed Q8.8. One item is handled at a time; s_axis_tready_o is high
// only between items. Each item takes four passes over the ring through the one
// multiply-accumulate unit (window sum, sum of squared deviations, lag-1 and lag-N
// cross terms) and three divisions on the shared divider; a flat window skips the
// lag-1 division and the lag-N pass and division, an out-of-range lag the lag-N pass
// and division. A finished result sits in the output register, so the next sample
// can be accepted while it waits. corr_lag is written through the cfg channel, which
// is always ready.
module autocorrelation_load_predictor
  import acl_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // [15:0] load_sample
  // Result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,   // [16:0] prediction, [32:17] lag1_correlation,
                                                 // [48:33] lag_correlation, [55:49] zero
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LAG_W-1:0]     cfg_data_i        // corr_lag
);

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int ACC_W = PROD_W + $clog2(WINDOW_LEN) + 1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SUM  = 10'b0000000010,
    S_MEAN = 10'b0000000100,
    S_DEN  = 10'b0000001000,
    S_NUM1 = 10'b0000010000,
    S_DIV1 = 10'b0000100000,
    S_NUML = 10'b0001000000,
    S_DIVL = 10'b0010000000,
    S_PRED = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     v1_q, v2_q;
  logic [SAMPLE_W-1:0]      newest_q, mean_q;
  logic [ACC_W-1:0]         den_q;
  logic                     neg_q;
  logic [CORR_W-1:0]        c1_q, cl_q;
  logic [LAG_W-1:0]         corr_lag_q;
  logic                     m_valid_q;
  logic [M_TDATA_W-1:0]     m_data_q;

  logic                     in_accept, in_pass, issuing, pass_done, out_free;
  logic                     lag_big, den_zero, sum_mode, pred_sel, div_start;
  logic [IDX_W-1:0]         pass_lag, oldest, addr_a, addr_b, k_b;
  logic [CNT_W-1:0]         pass_len;
  logic [SAMPLE_W-1:0]      rd_a, rd_b, mean_eff;
  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         acc_u, mag;
  logic [ACC_W-1:0]         div_hi, div_divisor;
  logic [QUOT_W-1:0]        div_lo, quot;
  mac_ctl_t                 mac_ctl;
  div_stat_t                div_stat;

  // Chronological offset to physical ring slot
  function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (IDX_W + 1)'(WINDOW_LEN)) begin
      s = s - (IDX_W + 1)'(WINDOW_LEN);
    end
    return s[IDX_W-1:0];
  endfunction

  // Quotient magnitude to signed Q1.15 with saturation of +1.0
  function automatic logic [CORR_W-1:0] to_corr(input logic [QUOT_W-1:0] q, input logic neg);
    logic [QUOT_W:0] n;
    n = -{1'b0, q};
    if (neg) begin
      return n[CORR_W-1:0];
    end else if (q > CORR_MAX) begin
      return CORR_MAX;
    end else begin
      return q;
    end
  endfunction

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign lag_big         = int'(corr_lag_q) >= WINDOW_LEN;
  assign den_zero        = (den_q == '0);

  // Pass control: lag and length of the current pass over the ring
  assign in_pass  = (state_q == S_SUM) || (state_q == S_DEN) ||
                    (state_q == S_NUM1) || (state_q == S_NUML);
  assign pass_lag = (state_q == S_NUM1) ? IDX_W'(1) :
                    (state_q == S_NUML) ? IDX_W'(corr_lag_q) : '0;
  assign pass_len = CNT_W'(WINDOW_LEN) - CNT_W'(pass_lag);
  assign issuing  = in_pass && (cnt_q < pass_len);
  assign pass_done = in_pass && (cnt_q == pass_len) && !v1_q && !v2_q;

  // Read addresses in chronological order, oldest first
  assign k_b    = cnt_q[IDX_W-1:0] + pass_lag;
  assign addr_a = ring_addr(oldest, cnt_q[IDX_W-1:0]);
  assign addr_b = ring_addr(oldest, k_b);

  acl_ring #(
    .DEPTH (WINDOW_LEN)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (in_accept),
    .wr_data_i   (s_axis_tdata_i[SAMPLE_W-1:0]),
    .rd_addr_a_i (addr_a),
    .rd_addr_b_i (addr_b),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b),
    .oldest_o    (oldest)
  );

  // Multiplier operands: deviations, raw samples for the sum, or the prediction
  assign sum_mode = (state_q == S_SUM);
  assign pred_sel = (state_q == S_PRED) || (state_q == S_DONE);
  assign mean_eff = sum_mode ? '0 : mean_q;

  always_comb begin
    if (pred_sel) begin
      op_a = signed'({1'b0, newest_q});
      op_b = signed'({c1_q[CORR_W-1], c1_q});
    end else begin
      op_a = signed'({1'b0, rd_a} - {1'b0, mean_eff});
      op_b = sum_mode ? OP_W'(1) : signed'({1'b0, rd_b} - {1'b0, mean_q});
    end
  end

  acl_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  // Divider operands: window sum by length, or |num| * 2^15 by den
  assign acc_u       = unsigned'(acc);
  assign mag         = acc[ACC_W-1] ? (~acc_u + 1'b1) : acc_u;
  assign div_hi      = sum_mode ? (acc_u >> QUOT_W) : (mag >> 1);
  assign div_lo      = sum_mode ? acc_u[QUOT_W-1:0] : {mag[0], {(QUOT_W - 1){1'b0}}};
  assign div_divisor = sum_mode ? ACC_W'(WINDOW_LEN) : den_q;

  acl_div #(
    .W (ACC_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .hi_i      (div_hi),
    .lo_i      (div_lo),
    .divisor_i (div_divisor),
    .stat_o    (div_stat),
    .quot_o    (quot)
  );

  // Sequencer; the accumulator adds whenever a product leaves the pipeline
  always_comb begin
    state_d        = state_q;
    div_start      = 1'b0;
    mac_ctl.clear  = 1'b0;
    mac_ctl.acc_en = v2_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d       = S_SUM;
          mac_ctl.clear = 1'b1;
        end
      end
      S_SUM: begin
        if (pass_done) begin
          state_d       = S_MEAN;
          div_start     = 1'b1;
          mac_ctl.clear = 1'b1;
        end
      end
      S_MEAN: begin
        if (div_stat.done) begin
          state_d = S_DEN;
        end
      end
      S_DEN: begin
        if (pass_done) begin
          state_d       = S_NUM1;
          mac_ctl.clear = 1'b1;
        end
      end
      S_NUM1: begin
        if (pass_done) begin
          mac_ctl.clear = 1'b1;
          if (den_zero) begin
            state_d = S_PRED;
          end else begin
            state_d   = S_DIV1;
            div_start = 1'b1;
          end
        end
      end
      S_DIV1: begin
        if (div_stat.done) begin
          state_d = lag_big ? S_PRED : S_NUML;
        end
      end
      S_NUML: begin
        if (pass_done) begin
          state_d       = S_DIVL;
          div_start     = 1'b1;
          mac_ctl.clear = 1'b1;
        end
      end
      S_DIVL: begin
        if (div_stat.done) begin
          state_d = S_PRED;
        end
      end
      S_PRED: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Pass counter
  always_comb begin
    if (!in_pass || pass_done) begin
      cnt_d = '0;
    end else if (issuing) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      m_valid_q  <= 1'b0;
      corr_lag_q <= LAG_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= issuing;
      v2_q    <= v1_q;
      if (cfg_valid_i && cfg_ready_o) begin
        corr_lag_q <= cfg_data_i;
      end
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Per-item results
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      newest_q <= s_axis_tdata_i[SAMPLE_W-1:0];
    end
    if (state_q == S_MEAN && div_stat.done) begin
      mean_q <= quot;
    end
    if (state_q == S_DEN && pass_done) begin
      den_q <= acc_u;
    end
    if (div_start) begin
      neg_q <= acc[ACC_W-1];
    end
    if (state_q == S_NUM1 && pass_done && den_zero) begin
      c1_q <= '0;
      cl_q <= '0;
    end
    if (state_q == S_DIV1 && div_stat.done) begin
      c1_q <= to_corr(quot, neg_q);
      if (lag_big) begin
        cl_q <= '0;
      end
    end
    if (state_q == S_DIVL && div_stat.done) begin
      cl_q <= to_corr(quot, neg_q);
    end
    if (state_q == S_DONE && out_free) begin
      m_data_q <= {{(M_TDATA_W - PRED_W - 2 * CORR_W){1'b0}}, cl_q, c1_q,
                   prod[PRED_W+QUOT_W-2:QUOT_W-1]};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  // Between items no read, product or division is still in flight
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!v1_q && !v2_q && !div_stat.busy))
    else $error("work in flight while ready for a new sample");

  // An accepted sample starts the sequence at once
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o)
    else $error("still ready after accepting a sample");

  // The divider is only started when free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A finished item always lands in the output register
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> m_axis_tvalid_o)
    else $error("result not presented after completion");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the autocorrelation load predictor.
`timescale 1ns / 1ps

module testbench;
  import acl_pkg::*;

  localparam int     WINDOW      = WINDOW_LEN_DEF;
  localparam int     HOLD_CYCLES = 2500;
  localparam longint LIMIT_NS    = 20_000_000;
  localparam int     MAX_PRINTS  = 100;

  // Shapes of the random sample bursts
  typedef enum int {FLAT_RUN, ALTERNATE, RAMP, NOISE, NEAR_FLAT, EXTREMES} burst_e;

  // One predicted result transaction
  typedef struct {
    logic signed [PRED_W-1:0] prediction;
    logic signed [CORR_W-1:0] lag1_corr;
    logic signed [CORR_W-1:0] lagn_corr;
    int                       seq;
  } load_forecast_t;

  // Predictor: own copy of the ring, the lag register and the pending forecasts
  class load_scoreboard;
    logic [SAMPLE_W-1:0] ring [WINDOW];
    int unsigned         head;          // next write slot, also the oldest sample
    logic [LAG_W-1:0]    lag;
    bit                  flat;
    load_forecast_t      forecasts[$];
    int                  errors;
    int                  samples;
    int                  results;
    int                  flat_windows;
    int                  lag_writes;

    function new();
      foreach (ring[i]) ring[i] = '0;
      head = 0;
      lag  = LAG_RST;
    endfunction

    function void set_lag(logic [LAG_W-1:0] v);
      lag = v;
      lag_writes++;
    endfunction

    function int pending();
      return forecasts.size();
    endfunction

    // k-th sample in time order, 0 = oldest
    function longint chrono(int unsigned k);
      return longint'(ring[(head + k) % WINDOW]);
    endfunction

    // Normalized autocorrelation in Q1.15, truncated toward zero and saturated
    function logic signed [CORR_W-1:0] corr_at(int unsigned lag_v, longint mean);
      longint          num;
      longint          den;
      longint          dev;
      longint unsigned mag;
      longint          q;
      bit              neg;
      num = 0;
      den = 0;
      if (lag_v >= WINDOW) return '0;
      for (int unsigned i = 0; i + lag_v < WINDOW; i++)
        num += (chrono(i) - mean) * (chrono(i + lag_v) - mean);
      for (int unsigned i = 0; i < WINDOW; i++) begin
        dev = chrono(i) - mean;
        den += dev * dev;
      end
      flat = (den == 0);
      if (den == 0) return '0;
      neg = (num < 0);
      mag = neg ? -num : num;
      mag = (mag << 15) / den;
      if (mag > 32768) mag = 32768;
      q = neg ? -longint'(mag) : longint'(mag);
      if (q > 32767) q = 32767;
      return q[CORR_W-1:0];
    endfunction

    // Accepted sample: update the ring and queue the expected result
    function void note_sample(logic [SAMPLE_W-1:0] load_v);
      longint         sum;
      longint         mean;
      longint         p;
      load_forecast_t f;
      ring[head] = load_v;
      head = (head + 1) % WINDOW;
      sum = 0;
      foreach (ring[i]) sum += ring[i];
      mean = sum / WINDOW;
      f.lag1_corr = corr_at(1, mean);
      f.lagn_corr = corr_at(lag, mean);
      if (flat) flat_windows++;
      p = longint'(load_v) * longint'(f.lag1_corr);
      p = p >>> 15;
      f.prediction = p[PRED_W-1:0];
      f.seq = samples++;
      forecasts.push_back(f);
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one result transaction with the oldest forecast
    task check_result(logic [M_TDATA_W-1:0] tdata);
      load_forecast_t           f;
      logic signed [PRED_W-1:0] pr;
      logic signed [CORR_W-1:0] c1;
      logic signed [CORR_W-1:0] cn;
      pr = tdata[PRED_W-1:0];
      c1 = tdata[PRED_W +: CORR_W];
      cn = tdata[PRED_W+CORR_W +: CORR_W];
      results++;
      if (forecasts.size() == 0) begin
        report($sformatf("result %0d arrived with no sample outstanding", results));
        return;
      end
      f = forecasts.pop_front();
      if (pr !== f.prediction || c1 !== f.lag1_corr || cn !== f.lagn_corr)
        report($sformatf("sample %0d: prediction %0d exp %0d, lag1 %0d exp %0d, lagN %0d exp %0d",
                         f.seq, pr, f.prediction, c1, f.lag1_corr, cn, f.lagn_corr));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [LAG_W-1:0]     cfg_data = '0;

  load_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;

  autocorrelation_load_predictor #(
    .WINDOW_LEN(WINDOW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request
  int hold_seen = 0;
  int hold_cnt  = 0;
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_cnt  = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) sb.check_result(m_axis_tdata_o);
  end

  // Offer one sample, with random idle cycles ahead of it
  task automatic send_load(input logic [SAMPLE_W-1:0] load_v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= load_v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sample(load_v);
  endtask

  // Register write, only issued while the block is idle
  task automatic write_lag(input logic [LAG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_lag(v);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Random bursts: mostly structured load traces, some plain noise
  task automatic run_random(input int quota);
    int                  sent;
    int                  r;
    int                  len;
    int                  step;
    burst_e              kind;
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] alt;
    sent = 0;
    while (sent < quota) begin
      r = $urandom_range(99);
      if (r < 6)       kind = FLAT_RUN;
      else if (r < 30) kind = ALTERNATE;
      else if (r < 50) kind = RAMP;
      else if (r < 70) kind = NOISE;
      else if (r < 88) kind = NEAR_FLAT;
      else             kind = EXTREMES;
      v    = $urandom_range(65535);
      alt  = $urandom_range(65535);
      step = $urandom_range(4095) - 2048;
      case (kind)
        FLAT_RUN:  len = $urandom_range(72, WINDOW);
        NEAR_FLAT: len = $urandom_range(70, 16);
        NOISE:     len = $urandom_range(24, 1);
        EXTREMES:  len = $urandom_range(12, 1);
        default:   len = $urandom_range(48, 8);
      endcase
      // last burst is cut to the quota
      if (len > quota - sent) len = quota - sent;
      for (int i = 0; i < len; i++) begin
        case (kind)
          FLAT_RUN:  send_load(v);
          ALTERNATE: send_load(i[0] ? alt : v);
          RAMP:      send_load(v + step[SAMPLE_W-1:0] * i[SAMPLE_W-1:0]);
          NOISE:     send_load($urandom_range(65535));
          NEAR_FLAT: send_load(v + SAMPLE_W'($urandom_range(3)));
          EXTREMES: begin
            r = $urandom_range(3);
            send_load(r == 0 ? 16'h0000 : r == 1 ? 16'hFFFF : r == 2 ? 16'h0001 : 16'hFFFE);
          end
          default:   send_load(v);
        endcase
        sent++;
      end
    end
  endtask

  // One idling setting, two lag settings
  task automatic run_phase(input int s_pct, input int r_pct, input logic [LAG_W-1:0] lag_a,
                           input logic [LAG_W-1:0] lag_b, input int quota, input bit with_hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_lag(lag_a);
    if (with_hold) begin
      // receiver backs off while samples keep coming, so the input stalls
      hold_reqs <= hold_reqs + 1;
      for (int i = 0; i < 12; i++) send_load($urandom_range(65535));
    end
    run_random(quota / 2);
    drain_results();
    write_lag(lag_b);
    run_random(quota - quota / 2);
    drain_results();
  endtask

  // Main sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);
    send_idle_pct = 18;
    recv_idle_pct = 54;

    // Directed, lag at its reset value: cleared ring, spikes, alternation, bit patterns
    send_load(16'h0000);
    send_load(16'hFFFF);
    send_load(16'h0000);
    send_load(16'hFFFF);
    send_load(16'h0000);
    send_load(16'hFFFF);
    send_load(16'h5555);
    send_load(16'hAAAA);
    send_load(16'h0001);
    send_load(16'h8000);
    send_load(16'hFFFF);
    send_load(16'hFFFF);
    drain_results();
    // lag zero: correlation of a window with itself saturates
    write_lag('0);
    send_load(16'h1234);
    send_load(16'hFFFF);
    send_load(16'h0000);
    drain_results();
    // largest lag: only the oldest and newest samples pair up
    write_lag('1);
    send_load(16'h00FF);
    send_load(16'hFF00);
    send_load(16'h7FFF);
    send_load(16'h8000);
    drain_results();

    run_phase(18, 54, 6'd63, 6'($urandom_range(62, 2)), 310, 1'b1);
    run_phase(54, 18, 6'd0, 6'd1, 310, 1'b0);
    run_phase(0, 0, 6'd32, 6'($urandom_range(63)), 310, 1'b0);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d load samples and %0d checked results over %0d lag writes.",
             sb.samples, sb.results, sb.lag_writes);
    $display("%0d results came from a flat window; one long receiver hold-off stalled the input.",
             sb.flat_windows);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** autocorrelation_load_predictor: PASSED **");
    end else begin
      $display("** autocorrelation_load_predictor: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d results outstanding.", sb.pending());
    $display("** autocorrelation_load_predictor: FAILED **");
    $finish;
  end

endmodule
